FILE: hw/rtl/pkbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkbd_pkg: shared types and codes of the prefix key block entry decoder
// Entry phases, result kinds, status codes and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pkbd_pkg;

	// Default upper bound on a reconstructed key, in bytes.
	localparam int MAX_KEY_LEN_DEF = 32;

	// Position inside an entry.
	typedef enum logic [2:0] {
		PH_SHARED  = 3'd0,
		PH_TAILLEN = 3'd1,
		PH_VALLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_VALUE   = 3'd4
	} phase_t;

	// Result kinds.
	localparam logic [1:0] K_KEY       = 2'd0;
	localparam logic [1:0] K_VALUE     = 2'd1;
	localparam logic [1:0] K_ENTRY_END = 2'd2;
	localparam logic [1:0] K_BLOCK_END = 2'd3;

	// Status codes carried by marker results.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_VARINT = 3'd1;
	localparam logic [2:0] ST_TRUNCATED  = 3'd2;
	localparam logic [2:0] ST_BAD_PREFIX = 3'd3;
	localparam logic [2:0] ST_KEY_LONG   = 3'd4;

	// Which pending result goes to the output register.
	typedef enum logic [2:0] {
		SEL_DATA   = 3'd0,
		SEL_REPLAY = 3'd1,
		SEL_MARK   = 3'd2,
		SEL_TRUNC  = 3'd3,
		SEL_BLOCK  = 3'd4
	} emit_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      eval;
		logic      rd;
		logic      emit;
		emit_sel_t sel;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic data_pend;
		logic replay_pend;
		logic mark_pend;
		logic trunc_pend;
		logic blk_pend;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: hw/rtl/pkbd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkbd_ctrl: sequencing controller
// Accepts one byte, has the datapath evaluate it, then hands the pending
// results to the output register one at a time in their fixed order.
// ----------------------------------------------------------------------------
module pkbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pkbd_pkg::dp_stat_t stat,
	output pkbd_pkg::dp_cmd_t  cmd
);
	import pkbd_pkg::*;

	typedef enum logic [2:0] {
		S_SEQ   = 3'b001,
		S_EVAL  = 3'b010,
		S_FETCH = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   none_pend;

	// Nothing left to deliver for the current byte.
	assign none_pend = !(stat.data_pend || stat.replay_pend || stat.mark_pend ||
		stat.trunc_pend || stat.blk_pend);

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.sel  = SEL_DATA;
		in_stall = 1'b1;
		unique case (state_q)
			S_SEQ: begin
				priority if (none_pend) begin
					in_stall = 1'b0;
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = S_EVAL;
					end
				end else if (stat.data_pend) begin
					if (stat.out_free) begin
						cmd.emit = 1'b1;
						cmd.sel  = SEL_DATA;
					end
				end else if (stat.replay_pend) begin
					cmd.rd  = 1'b1;
					state_d = S_FETCH;
				end else if (stat.mark_pend) begin
					if (stat.out_free) begin
						cmd.emit = 1'b1;
						cmd.sel  = SEL_MARK;
					end
				end else if (stat.trunc_pend) begin
					if (stat.out_free) begin
						cmd.emit = 1'b1;
						cmd.sel  = SEL_TRUNC;
					end
				end else begin
					if (stat.out_free) begin
						cmd.emit = 1'b1;
						cmd.sel  = SEL_BLOCK;
					end
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_SEQ;
			end
			S_FETCH: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_REPLAY;
					state_d  = S_SEQ;
				end
			end
			default: begin
				state_d = S_SEQ;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SEQ;
		end else begin
			state_q <= state_d;
		end
	end

	// A replayed byte is only fetched when one is owed.
	a_fetch_owed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (stat.replay_pend && !stat.data_pend))
		else $error("prefix fetch issued with no replay owed");

	// An accepted byte always moves the controller to its evaluate state.
	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_EVAL)
		else $error("accepted byte was not evaluated next cycle");

endmodule

FILE: hw/rtl/pkbd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkbd_dp: entry decoding datapath
// Holds the header state, the previous-key store, the per-byte result plan
// and the output register.
// ----------------------------------------------------------------------------
module pkbd_dp #(
	parameter int MAX_KEY_LEN = pkbd_pkg::MAX_KEY_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pkbd_pkg::dp_cmd_t   cmd,
	output pkbd_pkg::dp_stat_t  stat,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic [1:0]          out_kind,
	output logic [2:0]          status,
	output logic                run_last
);
	import pkbd_pkg::*;

	localparam int KW = $clog2(MAX_KEY_LEN + 1);
	localparam int AW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

	// Captured input transaction.
	logic [7:0]    byte_q;
	logic          last_q;

	// Decoder state.
	phase_t        phase_q, n_phase;
	logic [31:0]   acc_q, n_acc;
	logic [2:0]    cnt_q, n_cnt;
	logic [31:0]   shared_q, n_shared;
	logic [31:0]   tail_q, n_tail;
	logic [31:0]   value_q, n_value;
	logic [KW-1:0] keylen_q, n_keylen;
	logic [KW-1:0] wpos_q, n_wpos;
	logic          err_q, n_err;

	// Result plan for the current byte.
	logic [7:0]    dbyte_q;
	logic [1:0]    dkind_q, p_dkind;
	logic          dpend_q, p_dpend;
	logic [KW-1:0] rleft_q, p_rleft;
	logic [KW-1:0] ridx_q;
	logic          mpend_q, p_mpend;
	logic [2:0]    mst_q, p_mst;
	logic          tpend_q, p_tpend;
	logic          bpend_q;

	// Previous-key store.
	logic [7:0]    key_mem [MAX_KEY_LEN];
	logic [7:0]    rd_q;
	logic          wr_en;

	// Output register.
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic [1:0]    out_kind_q;
	logic [2:0]    status_q;
	logic          run_last_q;

	// Varint helpers.
	logic [5:0]    sh;
	logic [31:0]   grp;
	logic [31:0]   acc_new;
	logic [2:0]    cnt_new;
	logic [32:0]   klen_sum;

	assign sh       = {cnt_q, 3'b000} - {3'b000, cnt_q};
	assign grp      = {25'd0, byte_q[6:0]} << sh;
	assign acc_new  = acc_q | grp;
	assign cnt_new  = cnt_q + 3'd1;
	assign klen_sum = {1'b0, shared_q} + {1'b0, tail_q};

	// Evaluation of one byte against the current state.
	always_comb begin
		n_phase  = phase_q;
		n_acc    = acc_q;
		n_cnt    = cnt_q;
		n_shared = shared_q;
		n_tail   = tail_q;
		n_value  = value_q;
		n_keylen = keylen_q;
		n_wpos   = wpos_q;
		n_err    = err_q;
		p_dpend  = 1'b0;
		p_dkind  = K_KEY;
		p_rleft  = '0;
		p_mpend  = 1'b0;
		p_mst    = ST_OK;
		wr_en    = 1'b0;
		if (!err_q) begin
			unique case (phase_q)
				PH_KEY: begin
					wr_en   = (wpos_q < KW'(MAX_KEY_LEN));
					n_wpos  = wpos_q + KW'(1);
					p_dpend = 1'b1;
					p_dkind = K_KEY;
					n_tail  = tail_q - 32'd1;
					if (tail_q == 32'd1) begin
						if (value_q != 32'd0) begin
							n_phase = PH_VALUE;
						end else begin
							p_mpend = 1'b1;
							n_phase = PH_SHARED;
						end
					end
				end
				PH_VALUE: begin
					p_dpend = 1'b1;
					p_dkind = K_VALUE;
					n_value = value_q - 32'd1;
					if (value_q == 32'd1) begin
						p_mpend = 1'b1;
						n_phase = PH_SHARED;
					end
				end
				default: begin
					if (byte_q[7]) begin
						// Continuation byte: keep collecting groups.
						n_acc = acc_new;
						n_cnt = cnt_new;
						if (cnt_new >= 3'd5) begin
							p_mpend = 1'b1;
							p_mst   = ST_BAD_VARINT;
							n_err   = 1'b1;
						end
					end else begin
						n_acc = '0;
						n_cnt = '0;
						unique case (phase_q)
							PH_SHARED: begin
								n_shared = acc_new;
								n_phase  = PH_TAILLEN;
							end
							PH_TAILLEN: begin
								n_tail  = acc_new;
								n_phase = PH_VALLEN;
							end
							default: begin
								// Header complete: check it and plan the prefix replay.
								n_value = acc_new;
								priority if (shared_q > 32'(keylen_q)) begin
									p_mpend = 1'b1;
									p_mst   = ST_BAD_PREFIX;
									n_err   = 1'b1;
								end else if (klen_sum > 33'(MAX_KEY_LEN)) begin
									p_mpend = 1'b1;
									p_mst   = ST_KEY_LONG;
									n_err   = 1'b1;
								end else begin
									p_rleft  = shared_q[KW-1:0];
									n_wpos   = shared_q[KW-1:0];
									n_keylen = klen_sum[KW-1:0];
									priority if (tail_q != 32'd0) begin
										n_phase = PH_KEY;
									end else if (acc_new != 32'd0) begin
										n_phase = PH_VALUE;
									end else begin
										p_mpend = 1'b1;
										n_phase = PH_SHARED;
									end
								end
							end
						endcase
					end
				end
			endcase
		end
		p_tpend = last_q && !n_err && ((n_phase != PH_SHARED) || (n_cnt != 3'd0));
	end

	// Control state, plan flags and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SHARED;
			acc_q       <= '0;
			cnt_q       <= '0;
			shared_q    <= '0;
			tail_q      <= '0;
			value_q     <= '0;
			keylen_q    <= '0;
			wpos_q      <= '0;
			err_q       <= 1'b0;
			dpend_q     <= 1'b0;
			rleft_q     <= '0;
			ridx_q      <= '0;
			mpend_q     <= 1'b0;
			tpend_q     <= 1'b0;
			bpend_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.eval) begin
				if (last_q) begin
					phase_q  <= PH_SHARED;
					acc_q    <= '0;
					cnt_q    <= '0;
					shared_q <= '0;
					tail_q   <= '0;
					value_q  <= '0;
					keylen_q <= '0;
					wpos_q   <= '0;
					err_q    <= 1'b0;
				end else begin
					phase_q  <= n_phase;
					acc_q    <= n_acc;
					cnt_q    <= n_cnt;
					shared_q <= n_shared;
					tail_q   <= n_tail;
					value_q  <= n_value;
					keylen_q <= n_keylen;
					wpos_q   <= n_wpos;
					err_q    <= n_err;
				end
				dpend_q <= p_dpend;
				rleft_q <= p_rleft;
				ridx_q  <= '0;
				mpend_q <= p_mpend;
				tpend_q <= p_tpend;
				bpend_q <= last_q;
			end
			if (cmd.emit) begin
				unique case (cmd.sel)
					SEL_DATA: dpend_q <= 1'b0;
					SEL_REPLAY: begin
						rleft_q <= rleft_q - KW'(1);
						ridx_q  <= ridx_q + KW'(1);
					end
					SEL_MARK:  mpend_q <= 1'b0;
					SEL_TRUNC: tpend_q <= 1'b0;
					SEL_BLOCK: bpend_q <= 1'b0;
					default: begin
					end
				endcase
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= data_byte;
			last_q <= last_byte;
		end
		if (cmd.eval) begin
			dbyte_q <= byte_q;
			dkind_q <= p_dkind;
			mst_q   <= p_mst;
		end
		if (cmd.emit) begin
			unique case (cmd.sel)
				SEL_DATA: begin
					out_byte_q <= dbyte_q;
					out_kind_q <= dkind_q;
					status_q   <= ST_OK;
					run_last_q <= !(mpend_q || tpend_q || bpend_q);
				end
				SEL_REPLAY: begin
					out_byte_q <= rd_q;
					out_kind_q <= K_KEY;
					status_q   <= ST_OK;
					run_last_q <= (rleft_q == KW'(1)) && !(mpend_q || tpend_q || bpend_q);
				end
				SEL_MARK: begin
					out_byte_q <= 8'd0;
					out_kind_q <= K_ENTRY_END;
					status_q   <= mst_q;
					run_last_q <= !(tpend_q || bpend_q);
				end
				SEL_TRUNC: begin
					out_byte_q <= 8'd0;
					out_kind_q <= K_ENTRY_END;
					status_q   <= ST_TRUNCATED;
					run_last_q <= !bpend_q;
				end
				SEL_BLOCK: begin
					out_byte_q <= 8'd0;
					out_kind_q <= K_BLOCK_END;
					status_q   <= ST_OK;
					run_last_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Key store: one write port for the key tail, one registered read port
	// for the prefix replay.
	always_ff @(posedge clk) begin
		if (cmd.eval && wr_en) begin
			key_mem[wpos_q[AW-1:0]] <= byte_q;
		end
		if (cmd.rd) begin
			rd_q <= key_mem[ridx_q[AW-1:0]];
		end
	end

	assign stat.data_pend   = dpend_q;
	assign stat.replay_pend = (rleft_q != '0);
	assign stat.mark_pend   = mpend_q;
	assign stat.trunc_pend  = tpend_q;
	assign stat.blk_pend    = bpend_q;
	assign stat.out_free    = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_kind  = out_kind_q;
	assign status    = status_q;
	assign run_last  = run_last_q;

	// A result is never loaded over one that is still waiting to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && out_stall))
		else $error("output register overwritten while stalled");

	// The final byte of a block leaves the decoder at its start state.
	a_block_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval && last_q) |=> (phase_q == PH_SHARED && keylen_q == '0 && !err_q))
		else $error("decoder state not cleared after block end");

	// A prefix replay is only owed for a header that passed its checks.
	a_replay_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rleft_q != '0) |-> (mst_q == ST_OK && !(dpend_q && mpend_q && mst_q != ST_OK)))
		else $error("prefix replay pending alongside an error marker");

endmodule

FILE: hw/rtl/prefix_key_block_entry_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_key_block_entry_decoder: prefix-compressed block entry decoder
// Decodes the entries of a key/value block data region, one raw byte per
// transaction, into tagged key and value bytes with entry and block markers.
// ----------------------------------------------------------------------------
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid, in_stall  | data_byte, last_byte
//  output  | out_valid, out_stall| out_byte, out_kind, status, run_last
//
//  A byte is accepted, then evaluated, then each result it yields enters the
//  output register in turn; each replayed prefix byte is first fetched
//  through the single registered read port of the key store.
//  Reset clears all control state at once; the key store has no reset and
//  is never read beyond the current key length, so no clearing pass runs.
//  A stalled output holds the sequence; input is stalled until every result
//  of the current byte has entered the output register.
// ----------------------------------------------------------------------------
module prefix_key_block_entry_decoder #(
	parameter int MAX_KEY_LEN = pkbd_pkg::MAX_KEY_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind,
	output logic [2:0] status,
	output logic       run_last
);
	import pkbd_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencing controller.
	pkbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Decoding datapath with key store and output register.
	pkbd_dp #(
		.MAX_KEY_LEN (MAX_KEY_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_kind  (out_kind),
		.status    (status),
		.run_last  (run_last)
	);

endmodule
